[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the span engine datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSFR_CHK_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSFR_CHK_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/csfr_pkg.sv]
// ----------------------------------------------------------------------------
// csfr_pkg
// Types and constants of the clipped span fill / remap engine.
// ----------------------------------------------------------------------------
package csfr_pkg;

   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 16;
   localparam int unsigned REMAP_ENTRIES = 256;

   localparam logic [1:0] ACT_SPAN   = 2'd0;
   localparam logic [1:0] ACT_WPIX   = 2'd1;
   localparam logic [1:0] ACT_RPIX   = 2'd2;
   localparam logic [1:0] ACT_REMAPW = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_CLIP_LEFT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_BOTTOM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REMAP_ENABLE = 3'd4;

   localparam logic [15:0] CLIP_LEFT_RST   = 16'd0;
   localparam logic [15:0] CLIP_RIGHT_RST  = 16'd320;
   localparam logic [15:0] BAND_TOP_RST    = 16'd0;
   localparam logic [15:0] BAND_BOTTOM_RST = 16'd200;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  color;
      logic [15:0] col;
      logic [15:0] row;
      logic [15:0] span_width;
      logic [15:0] pixel_addr;
      logic [7:0]  remap_index;
   } req_type;

   typedef struct packed {
      logic [14:0] pixels_drawn;
      logic        rejected;
      logic [7:0]  read_byte;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic chk;
      logic lclip;
      logic endc;
      logic rclip;
      logic red_load;
      logic red_step;
      logic fill_issue;
      logic pix_wr;
      logic pix_rd;
      logic remap_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       rej;
      logic       red_done;
      logic       fill_last;
      logic       fill_hold;
      logic       pipe_busy;
      logic       rsp_free;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CHECK,
      ST_LCLIP,
      ST_ENDC,
      ST_RCLIP,
      ST_ADDR,
      ST_REDUCE,
      ST_FILL,
      ST_DRAIN,
      ST_PWRITE,
      ST_PREAD,
      ST_DONE
   } state_type;

endpackage

[rtl/csfr_ctrl.sv]
// ----------------------------------------------------------------------------
// csfr_ctrl
// Span engine sequencer: clip, address reduce, fill, pixel/remap op, reply.
// ----------------------------------------------------------------------------
module csfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  csfr_pkg::sts_type  sts,
   output csfr_pkg::cmd_type  cmd
);

   csfr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         csfr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = csfr_pkg::ST_DISPATCH;
            end
         end
         csfr_pkg::ST_DISPATCH: begin
            unique case (sts.act)
               csfr_pkg::ACT_SPAN: state_in = csfr_pkg::ST_CHECK;
               csfr_pkg::ACT_WPIX,
               csfr_pkg::ACT_RPIX: begin
                  cmd.red_load = 1'b1;
                  state_in     = csfr_pkg::ST_REDUCE;
               end
               csfr_pkg::ACT_REMAPW: begin
                  cmd.remap_wr = 1'b1;
                  state_in     = csfr_pkg::ST_DONE;
               end
            endcase
         end
         csfr_pkg::ST_CHECK: begin
            cmd.chk  = 1'b1;
            state_in = csfr_pkg::ST_LCLIP;
         end
         csfr_pkg::ST_LCLIP: begin
            if (sts.rej) begin
               state_in = csfr_pkg::ST_DONE;
            end else begin
               cmd.lclip = 1'b1;
               state_in  = csfr_pkg::ST_ENDC;
            end
         end
         csfr_pkg::ST_ENDC: begin
            if (sts.rej) begin
               state_in = csfr_pkg::ST_DONE;
            end else begin
               cmd.endc = 1'b1;
               state_in = csfr_pkg::ST_RCLIP;
            end
         end
         csfr_pkg::ST_RCLIP: begin
            cmd.rclip = 1'b1;
            state_in  = csfr_pkg::ST_ADDR;
         end
         csfr_pkg::ST_ADDR: begin
            if (sts.rej) begin
               state_in = csfr_pkg::ST_DONE;
            end else begin
               cmd.red_load = 1'b1;
               state_in     = csfr_pkg::ST_REDUCE;
            end
         end
         csfr_pkg::ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (sts.red_done) begin
               unique case (sts.act)
                  csfr_pkg::ACT_SPAN:   state_in = csfr_pkg::ST_FILL;
                  csfr_pkg::ACT_WPIX:   state_in = csfr_pkg::ST_PWRITE;
                  csfr_pkg::ACT_RPIX:   state_in = csfr_pkg::ST_PREAD;
                  csfr_pkg::ACT_REMAPW: state_in = csfr_pkg::ST_DONE;
               endcase
            end
         end
         csfr_pkg::ST_FILL: begin
            if (!sts.fill_hold) begin
               cmd.fill_issue = 1'b1;
               if (sts.fill_last) begin
                  state_in = csfr_pkg::ST_DRAIN;
               end
            end
         end
         csfr_pkg::ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = csfr_pkg::ST_DONE;
            end
         end
         csfr_pkg::ST_PWRITE: begin
            cmd.pix_wr = 1'b1;
            state_in   = csfr_pkg::ST_DONE;
         end
         csfr_pkg::ST_PREAD: begin
            cmd.pix_rd = 1'b1;
            state_in   = csfr_pkg::ST_DONE;
         end
         csfr_pkg::ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = csfr_pkg::ST_IDLE;
            end
         end
         default: state_in = csfr_pkg::ST_IDLE;
      endcase
   end

endmodule

[rtl/csfr_dp.sv]
// ----------------------------------------------------------------------------
// csfr_dp
// Datapath: control registers, clip arithmetic, address reduction, frame and
// remap stores, three-stage pixel pipeline and the response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csfr_dp #(
   parameter int unsigned FRAME_DEPTH = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [csfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csfr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  csfr_pkg::req_type                   req_data,
   output csfr_pkg::rsp_type                   rsp_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  csfr_pkg::cmd_type                   cmd,
   output csfr_pkg::sts_type                   sts
);

   localparam int unsigned IW = $clog2(FRAME_DEPTH);
   localparam int unsigned QW = 17 - IW;
   localparam int unsigned KW = $clog2(QW + 1);

   // control registers
   logic [15:0] clip_left_ff, clip_right_ff, band_top_ff, band_bottom_ff;
   logic        remap_en_ff;

   // item registers
   logic [1:0]  act_ff, act_in;
   logic [7:0]  color_ff, color_in;
   logic [15:0] x_ff, x_in, y_ff, y_in, w_ff, w_in;
   logic [15:0] paddr_ff, paddr_in;
   logic [7:0]  ridx_ff, ridx_in;
   logic        rej_ff, rej_in;
   logic        lneg_ff, lneg_in;
   logic [15:0] amt_ff, amt_in;
   logic [15:0] span_end_ff, span_end_in;
   logic [14:0] drawn_ff, drawn_in;
   logic [15:0] r_ff, r_in;
   logic [KW-1:0] k_ff, k_in;
   logic [15:0] addr16_ff, addr16_in;
   logic [16:0] cnt_ff, cnt_in;

   // pixel pipeline
   logic          p1_v_ff, p2_v_ff;
   logic [IW-1:0] p1_idx_ff, p2_idx_ff;
   logic [7:0]    mem_q_ff, remap_q_ff;

   csfr_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_v_ff, rsp_v_in;

   logic [7:0] frame_mem [FRAME_DEPTH];
   logic [7:0] remap_mem [csfr_pkg::REMAP_ENTRIES];

   logic [15:0] dl, d2, start_addr, r_next;
   logic [16:0] sub_val, n_pix;
   logic [14:0] n_sat;
   logic [IW-1:0] cur_idx;
   logic [7:0]  fill_data;
   logic        fw_en, fr_en, byp;
   logic [IW-1:0] fw_idx;
   logic [7:0]  fw_data;

   assign dl         = x_ff - clip_left_ff;
   assign d2         = span_end_ff - clip_right_ff;
   assign start_addr = {y_ff[7:0], y_ff[15:8]} + {y_ff[9:0], 6'b0} + x_ff;
   assign n_pix      = (w_ff == 16'd0) ? 17'h10000 : {1'b0, w_ff};
   assign n_sat      = ((w_ff == 16'd0) || w_ff[15]) ? 15'h7FFF : w_ff[14:0];
   assign sub_val    = 17'(FRAME_DEPTH) << k_ff;
   assign cur_idx    = r_ff[IW-1:0];
   assign r_next     = ((addr16_ff == 16'hFFFF) || (r_ff == 16'(FRAME_DEPTH - 1))) ?
                       16'd0 : r_ff + 16'd1;
   assign fill_data  = remap_en_ff ? remap_q_ff : color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= csfr_pkg::CLIP_LEFT_RST;
         clip_right_ff  <= csfr_pkg::CLIP_RIGHT_RST;
         band_top_ff    <= csfr_pkg::BAND_TOP_RST;
         band_bottom_ff <= csfr_pkg::BAND_BOTTOM_RST;
         remap_en_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            csfr_pkg::REG_CLIP_LEFT:    clip_left_ff   <= csr_wdata;
            csfr_pkg::REG_CLIP_RIGHT:   clip_right_ff  <= csr_wdata;
            csfr_pkg::REG_BAND_TOP:     band_top_ff    <= csr_wdata;
            csfr_pkg::REG_BAND_BOTTOM:  band_bottom_ff <= csr_wdata;
            csfr_pkg::REG_REMAP_ENABLE: remap_en_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      act_in      = act_ff;
      color_in    = color_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      w_in        = w_ff;
      paddr_in    = paddr_ff;
      ridx_in     = ridx_ff;
      rej_in      = rej_ff;
      lneg_in     = lneg_ff;
      amt_in      = amt_ff;
      span_end_in = span_end_ff;
      drawn_in    = drawn_ff;
      r_in        = r_ff;
      k_in        = k_ff;
      addr16_in   = addr16_ff;
      cnt_in      = cnt_ff;

      if (cmd.load) begin
         act_in   = req_data.action;
         color_in = req_data.color;
         x_in     = req_data.col;
         y_in     = req_data.row;
         w_in     = req_data.span_width;
         paddr_in = req_data.pixel_addr;
         ridx_in  = req_data.remap_index;
         rej_in   = 1'b0;
         drawn_in = '0;
      end
      if (cmd.chk) begin
         rej_in  = ($signed(w_ff) <= 16'sd0) ||
                   ($signed(y_ff) < $signed(band_top_ff)) ||
                   ($signed(y_ff) >= $signed(band_bottom_ff));
         lneg_in = dl[15];
         amt_in  = clip_left_ff - x_ff;
      end
      if (cmd.lclip && lneg_ff) begin
         if ($signed(w_ff) <= $signed(amt_ff)) begin
            rej_in = 1'b1;
         end
         w_in = w_ff - amt_ff;
         x_in = clip_left_ff;
      end
      if (cmd.endc) begin
         span_end_in = x_ff + w_ff;
      end
      if (cmd.rclip && ($signed(span_end_ff) >= $signed(clip_right_ff))) begin
         if ($signed(w_ff) <= $signed(d2)) begin
            rej_in = 1'b1;
         end
         w_in = w_ff - d2;
      end
      if (cmd.red_load) begin
         k_in = KW'(QW - 1);
         if (act_ff == csfr_pkg::ACT_SPAN) begin
            r_in      = start_addr;
            addr16_in = start_addr;
            cnt_in    = n_pix;
            drawn_in  = n_sat;
         end else begin
            r_in = paddr_ff;
         end
      end
      if (cmd.red_step) begin
         if ({1'b0, r_ff} >= sub_val) begin
            r_in = r_ff - sub_val[15:0];
         end
         if (k_ff != '0) begin
            k_in = k_ff - 1'b1;
         end
      end
      if (cmd.fill_issue) begin
         r_in      = r_next;
         addr16_in = addr16_ff + 16'd1;
         cnt_in    = cnt_ff - 17'd1;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      color_ff    <= color_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      paddr_ff    <= paddr_in;
      ridx_ff     <= ridx_in;
      rej_ff      <= rej_in;
      lneg_ff     <= lneg_in;
      amt_ff      <= amt_in;
      span_end_ff <= span_end_in;
      drawn_ff    <= drawn_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      addr16_ff   <= addr16_in;
      cnt_ff      <= cnt_in;
   end

   // pixel pipeline: read, remap lookup, write back
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= cmd.fill_issue;
         p2_v_ff <= p1_v_ff;
      end
      p1_idx_ff <= cur_idx;
      p2_idx_ff <= p1_idx_ff;
   end

   always_comb begin
      fw_en   = p2_v_ff | cmd.pix_wr;
      fw_idx  = p2_v_ff ? p2_idx_ff : cur_idx;
      fw_data = p2_v_ff ? fill_data : color_ff;
      fr_en   = cmd.fill_issue | cmd.pix_rd;
      byp     = p2_v_ff && (p2_idx_ff == cur_idx);
   end

   always_ff @(posedge clock) begin
      if (fw_en) begin
         frame_mem[fw_idx] <= fw_data;
      end
      if (fr_en) begin
         mem_q_ff <= byp ? fill_data : frame_mem[cur_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.remap_wr) begin
         remap_mem[ridx_ff] <= color_ff;
      end
      remap_q_ff <= remap_mem[mem_q_ff];
   end

   // response word
   always_comb begin
      rsp_in   = rsp_ff;
      rsp_v_in = rsp_v_ff;
      if (rsp_ready) begin
         rsp_v_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_in.pixels_drawn = drawn_ff;
         rsp_in.rejected     = rej_ff;
         rsp_in.read_byte    = (act_ff == csfr_pkg::ACT_RPIX) ? mem_q_ff : 8'd0;
         rsp_v_in            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_v_ff;

   always_comb begin
      sts.act       = act_ff;
      sts.rej       = rej_ff;
      sts.red_done  = (k_ff == '0);
      sts.fill_last = (cnt_ff == 17'd1);
      sts.fill_hold = p1_v_ff && (p1_idx_ff == cur_idx);
      sts.pipe_busy = p1_v_ff | p2_v_ff;
      sts.rsp_free  = !rsp_v_ff || rsp_ready;
   end

   `CSFR_CHK_NOW(a_fill_idx_range, clock, reset, cmd.fill_issue, {1'b0, r_ff} < 17'(FRAME_DEPTH), "fill index beyond frame store")
   `CSFR_CHK_NOW(a_rej_no_pixels, clock, reset, rsp_v_ff && rsp_ff.rejected, rsp_ff.pixels_drawn == 15'd0, "rejected span reports pixels")
   `CSFR_CHK_NXT(a_pipe_advance, clock, reset, p1_v_ff, p2_v_ff, "pixel lost between read and write stage")
   `CSFR_CHK_NOW(a_no_write_clash, clock, reset, p2_v_ff, !cmd.pix_wr, "pixel write collides with span write-back")

endmodule

[rtl/clipped_span_fill_remap.sv]
// ----------------------------------------------------------------------------
// clipped_span_fill_remap
// Byte-per-pixel frame store with a clipped horizontal span engine.
//
// Request words (req_*) carry one action: draw span, write pixel, read pixel
// or write a remap entry. Each request yields exactly one response word
// (rsp_*), in order. One request is in flight at a time; req_ready is high
// only while the engine is idle, and a finished response waits in an output
// register so the next request can be taken while it is pending.
// Span: clip and address setup, then reduction of the start address, then
// one pixel per cycle through the frame store port, held while the pixel in
// the lookup stage has the same address (the remap path is a 3-stage
// read/lookup/write pipe), then a drain of that pipe. A rejected span skips
// the reduce and fill steps; pixel read/write also run the reduce steps, a
// remap write neither.
// The csr_* port writes clip_left, clip_right, band_top, band_bottom and
// remap_enable (index 0 to 4); write only while idle.
// Reset restores the register defaults and clears the sequencer; store
// contents are undefined until written. A stalled receiver holds the
// response word and the engine waits in its reply state.
// ----------------------------------------------------------------------------
module clipped_span_fill_remap #(
   parameter int unsigned FRAME_DEPTH = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  csfr_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output csfr_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [csfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [csfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   csfr_pkg::cmd_type cmd;
   csfr_pkg::sts_type sts;

   csfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   csfr_dp #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clipped span fill / remap engine. A short table
// of corner requests (store extremes, band and clip edges, 16-bit wrap of the
// left clip, saturated pixel counts) runs at reset settings. The remap table
// is then loaded, and random requests run under a series of register
// settings. Responses are checked against the table's word where given, else
// against an in-bench frame store, remap table and span clipper. The request
// side sends in bursts and the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import csfr_pkg::*;

   localparam int unsigned FRAME_DEPTH    = 65536;
   localparam int unsigned WATCHDOG_LIMIT = 300000;
   localparam int unsigned LONG_SPAN      = 1000;

   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_LONG} sink_mode_type;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } plan_entry;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the engine
   logic [15:0]   lim_left  = CLIP_LEFT_RST;
   logic [15:0]   lim_right = CLIP_RIGHT_RST;
   logic [15:0]   band_lo   = BAND_TOP_RST;
   logic [15:0]   band_hi   = BAND_BOTTOM_RST;
   logic          remap_on  = 1'b0;
   logic [7:0]    pix_mem   [FRAME_DEPTH];
   bit            pix_known [FRAME_DEPTH];
   logic [7:0]    lut_mem   [REMAP_ENTRIES];
   bit            lut_known [REMAP_ENTRIES];

   rsp_type       owed_replies [$];
   plan_entry     plan [$];
   int unsigned   mismatches   = 0;
   int unsigned   stuck_cycles = 0;
   int unsigned   burst_left   = 0;
   int unsigned   big_left     = 4;
   logic [7:0]    sink_tick    = '0;
   sink_mode_type sink_mode    = SINK_OPEN;

   clipped_span_fill_remap #(.FRAME_DEPTH(FRAME_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned pixel_slot(input int unsigned a);
      return (a & 32'hFFFF) % FRAME_DEPTH;
   endfunction

   // band check, left and right clip at 16 bits, start address
   function automatic void span_extent(input logic [15:0] x_in, y, w_in,
                                       output logic rej, output logic [15:0] base,
                                       output int unsigned n);
      logic [15:0] x, w, d, fin;
      x = x_in;
      w = w_in;
      rej = 1'b1;
      base = '0;
      n = 0;
      if ($signed(w) <= 0 || $signed(y) < $signed(band_lo) ||
          $signed(y) >= $signed(band_hi))
         return;
      d = x - lim_left;
      if ($signed(d) < 0) begin
         d = -d;
         if ($signed(w) <= $signed(d))
            return;
         w = w - d;
         x = lim_left;
      end
      fin = x + w;
      if ($signed(fin) >= $signed(lim_right)) begin
         d = fin - lim_right;
         if ($signed(w) <= $signed(d))
            return;
         w = w - d;
      end
      rej = 1'b0;
      base = {y[7:0], y[15:8]} + (y << 6) + x;
      n = (w == 16'd0) ? 32'd65536 : 32'(w);
   endfunction

   function automatic rsp_type serve_request(input req_type r);
      rsp_type     o;
      logic        rej;
      logic [15:0] base;
      int unsigned n, k;
      o = '0;
      case (r.action)
         ACT_SPAN: begin
            span_extent(r.col, r.row, r.span_width, rej, base, n);
            o.rejected = rej;
            if (!rej) begin
               for (int unsigned i = 0; i < n; i++) begin
                  k = pixel_slot(base + i);
                  if (remap_on)
                     pix_mem[k] = lut_mem[pix_mem[k]];
                  else
                     pix_mem[k] = r.color;
                  pix_known[k] = 1'b1;
               end
               o.pixels_drawn = (n > 32767) ? 15'd32767 : 15'(n);
            end
         end
         ACT_WPIX: begin
            k = pixel_slot(r.pixel_addr);
            pix_mem[k] = r.color;
            pix_known[k] = 1'b1;
         end
         ACT_RPIX: o.read_byte = pix_mem[pixel_slot(r.pixel_addr)];
         default: begin
            lut_mem[r.remap_index] = r.color;
            lut_known[r.remap_index] = 1'b1;
         end
      endcase
      return o;
   endfunction

   // true when the request reads nothing that was never written
   function automatic bit reads_known(input req_type r);
      logic        rej;
      logic [15:0] base;
      int unsigned n, k;
      if (r.action == ACT_RPIX)
         return pix_known[pixel_slot(r.pixel_addr)];
      if (r.action != ACT_SPAN || !remap_on)
         return 1'b1;
      span_extent(r.col, r.row, r.span_width, rej, base, n);
      if (rej)
         return 1'b1;
      for (int unsigned i = 0; i < n; i++) begin
         k = pixel_slot(base + i);
         if (!pix_known[k] || !lut_known[pix_mem[k]])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic req_type noise_word();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic plan_entry span_row(input logic [7:0] color,
                                          input logic [15:0] col, row, width,
                                          input bit typed, input logic [14:0] drawn,
                                          input logic rej);
      plan_entry e;
      e.word = noise_word();
      e.word.action = ACT_SPAN;
      e.word.color = color;
      e.word.col = col;
      e.word.row = row;
      e.word.span_width = width;
      e.typed = typed;
      e.want = '0;
      e.want.pixels_drawn = drawn;
      e.want.rejected = rej;
      return e;
   endfunction

   function automatic plan_entry misc_row(input logic [1:0] act, input logic [7:0] color,
                                          input logic [15:0] addr, input logic [7:0] idx,
                                          input bit typed, input logic [7:0] rd);
      plan_entry e;
      e.word = noise_word();
      e.word.action = act;
      e.word.color = color;
      e.word.pixel_addr = addr;
      e.word.remap_index = idx;
      e.typed = typed;
      e.want = '0;
      e.want.read_byte = rd;
      return e;
   endfunction

   function automatic req_type random_word();
      req_type     r;
      int          lo, hi, roll;
      logic        rej;
      logic [15:0] base;
      int unsigned n;
      r = noise_word();
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         r.action = ACT_SPAN;
         lo = $signed(band_lo);
         hi = $signed(band_hi);
         if (hi > lo)
            r.row = 16'(lo + $urandom_range(0, hi - lo - 1));
         lo = $signed(lim_left);
         hi = $signed(lim_right);
         r.col = 16'(lo - 40 + $urandom_range(0, (hi > lo ? hi - lo : 0) + 60));
         r.span_width = 16'($urandom_range(1, 360));
      end else if (roll < 70) begin
         r.action = ACT_SPAN;
         if ($urandom_range(0, 3) != 0)
            r.span_width = 16'($urandom_range(0, 400));
      end else if (roll < 80) begin
         r.action = ACT_WPIX;
      end else if (roll < 92) begin
         r.action = ACT_RPIX;
      end else begin
         r.action = ACT_REMAPW;
      end
      if (r.action == ACT_SPAN) begin
         span_extent(r.col, r.row, r.span_width, rej, base, n);
         if (!rej && n > LONG_SPAN) begin
            if (big_left > 0)
               big_left--;
            else
               r.action = ACT_RPIX;
         end
      end
      if (!reads_known(r))
         r.action = ACT_WPIX;
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type model;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      model = serve_request(w);
      owed_replies.push_back(typed ? want : model);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_CLIP_LEFT:    lim_left = data;
         REG_CLIP_RIGHT:   lim_right = data;
         REG_BAND_TOP:     band_lo = data;
         REG_BAND_BOTTOM:  band_hi = data;
         REG_REMAP_ENABLE: remap_on = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [15:0] left, right, top, bottom,
                                 input logic remap);
      req_valid <= 1'b0;
      while (owed_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
      csr_write(REG_CLIP_LEFT, left);
      csr_write(REG_CLIP_RIGHT, right);
      csr_write(REG_BAND_TOP, top);
      csr_write(REG_BAND_BOTTOM, bottom);
      csr_write(REG_REMAP_ENABLE, {15'd0, remap});
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_word(random_word(), 1'b0, '0);
   endtask

   always @(negedge clock) begin
      sink_tick <= sink_tick + 8'd1;
      if (sink_tick[5:0] == 6'd0)
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
      case (sink_mode)
         SINK_OPEN: rsp_ready <= 1'b1;
         SINK_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         SINK_SLOW: rsp_ready <= (sink_tick[1:0] == 2'd0);
         default:   rsp_ready <= (sink_tick[4:0] >= 5'd24);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected word: drawn=%0d rej=%0b rd=%02h", $time,
                        rsp_data.pixels_drawn, rsp_data.rejected, rsp_data.read_byte);
         end else begin
            want = owed_replies.pop_front();
            if (rsp_data.pixels_drawn !== want.pixels_drawn ||
                rsp_data.rejected !== want.rejected ||
                rsp_data.read_byte !== want.read_byte) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t word mismatch: want drawn=%0d rej=%0b rd=%02h, got drawn=%0d rej=%0b rd=%02h",
                           $time, want.pixels_drawn, want.rejected, want.read_byte,
                           rsp_data.pixels_drawn, rsp_data.rejected, rsp_data.read_byte);
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      req_type     w;
      logic [15:0] cl, bt;
      plan.push_back(misc_row(ACT_WPIX,   8'hFF, 16'h0000, 8'h00, 1'b1, 8'h00));
      plan.push_back(misc_row(ACT_RPIX,   8'h00, 16'h0000, 8'h00, 1'b1, 8'hFF));
      plan.push_back(misc_row(ACT_WPIX,   8'h00, 16'hFFFF, 8'hFF, 1'b1, 8'h00));
      plan.push_back(misc_row(ACT_RPIX,   8'hFF, 16'hFFFF, 8'hFF, 1'b1, 8'h00));
      plan.push_back(misc_row(ACT_REMAPW, 8'hA5, 16'h0000, 8'h00, 1'b1, 8'h00));
      plan.push_back(misc_row(ACT_REMAPW, 8'h5A, 16'hFFFF, 8'hFF, 1'b1, 8'h00));
      // width not positive, row outside the band
      plan.push_back(span_row(8'h11, 16'h0000, 16'h0000, 16'h0000, 1'b1, 15'd0, 1'b1));
      plan.push_back(span_row(8'h11, 16'h0000, 16'h0000, 16'h8000, 1'b1, 15'd0, 1'b1));
      plan.push_back(span_row(8'h11, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 15'd0, 1'b1));
      plan.push_back(span_row(8'h11, 16'h0000, 16'hFFFF, 16'h000A, 1'b1, 15'd0, 1'b1));
      plan.push_back(span_row(8'h11, 16'h0000, 16'd200,  16'h000A, 1'b1, 15'd0, 1'b1));
      plan.push_back(span_row(8'h12, 16'h0000, 16'h0000, 16'd320,  1'b1, 15'd320, 1'b0));
      // end wraps negative, no right clip
      plan.push_back(span_row(8'h34, 16'h7FFF, 16'd199,  16'h0001, 1'b0, 15'd0, 1'b0));
      plan.push_back(span_row(8'h56, 16'hFFF6, 16'd5,    16'd10,   1'b1, 15'd0, 1'b1));
      plan.push_back(span_row(8'h56, 16'hFFF6, 16'd5,    16'd11,   1'b1, 15'd1, 1'b0));
      plan.push_back(span_row(8'h78, 16'd310,  16'd6,    16'd10,   1'b1, 15'd10, 1'b0));
      plan.push_back(span_row(8'h78, 16'd320,  16'd6,    16'd5,    1'b1, 15'd0, 1'b1));
      plan.push_back(span_row(8'h9A, 16'hFFFF, 16'd199,  16'h7FFF, 1'b1, 15'd320, 1'b0));
      // left clip of 0x8000 wraps into very long spans, count saturates
      plan.push_back(span_row(8'h3C, 16'h8000, 16'd100,  16'h0001, 1'b1, 15'd32767, 1'b0));
      plan.push_back(span_row(8'hC3, 16'h8000, 16'h0000, 16'h7FFF, 1'b1, 15'd32767, 1'b0));
      plan.push_back(misc_row(ACT_RPIX,   8'h00, 16'h8000, 8'h00, 1'b0, 8'h00));
      plan.push_back(misc_row(ACT_RPIX,   8'h00, 16'h1234, 8'h00, 1'b0, 8'h00));
      plan.push_back(span_row(8'hFF, 16'h0000, 16'd199,  16'h0001, 1'b1, 15'd1, 1'b0));

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_word(plan[i].word, plan[i].typed, plan[i].want);

      for (int unsigned i = 0; i < REMAP_ENTRIES; i++) begin
         w = noise_word();
         w.action = ACT_REMAPW;
         w.remap_index = 8'(i);
         send_word(w, 1'b0, '0);
      end

      write_settings(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
      run_random(110);
      write_settings(16'd40, 16'd280, 16'd10, 16'd190, 1'b1);
      run_random(110);
      write_settings(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
      run_random(60);
      for (int p = 0; p < 4; p++) begin
         cl = 16'($urandom_range(0, 800) - 400);
         bt = 16'($urandom_range(0, 400) - 200);
         write_settings(cl, 16'(cl + $urandom_range(0, 600)), bt,
                        16'(bt + $urandom_range(0, 300)), 1'($urandom_range(0, 1)));
         run_random(110);
      end
      write_settings(CLIP_LEFT_RST, CLIP_RIGHT_RST, BAND_TOP_RST, BAND_BOTTOM_RST, 1'b1);
      run_random(100);

      req_valid <= 1'b0;
      while (owed_replies.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && owed_replies.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/csfr_pkg.sv
rtl/csfr_ctrl.sv
rtl/csfr_dp.sv
rtl/clipped_span_fill_remap.sv
tb/tb_top.sv
